>>> src/pcu_pkg.sv
package pcu_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int SRC_W = 64;
  localparam int IMM_W = 8;
  localparam int PRED_W = 6;

  localparam logic [1:0] OP_AND_TYPES    = 2'd0;
  localparam logic [1:0] OP_OR_TYPES     = 2'd1;
  localparam logic [1:0] OP_ORANDCM_TYPES = 2'd2;
  localparam logic [1:0] OP_NOT_COMPARE  = 2'd3;

  localparam logic [1:0] TAC_NONE = 2'd0;
  localparam logic [1:0] TAC_UNC  = 2'd1;
  localparam logic [1:0] TAC_EQ   = 2'd2;
  localparam logic [1:0] TAC_NE   = 2'd3;

  localparam logic [2:0] REL_EQ  = 3'd0;
  localparam logic [2:0] REL_NE  = 3'd1;
  localparam logic [2:0] REL_LT  = 3'd2;
  localparam logic [2:0] REL_LE  = 3'd3;
  localparam logic [2:0] REL_GT  = 3'd4;
  localparam logic [2:0] REL_GE  = 3'd5;
  localparam logic [2:0] REL_LTU = 3'd6;

  localparam logic [2:0] CT_NONE    = 3'd0;
  localparam logic [2:0] CT_UNC     = 3'd1;
  localparam logic [2:0] CT_AND     = 3'd2;
  localparam logic [2:0] CT_OR      = 3'd3;
  localparam logic [2:0] CT_ORANDCM = 3'd4;

  typedef struct packed {
    logic              active;
    logic              unimpl;
    logic [2:0]        rel;
    logic [2:0]        ctype;
    logic [SRC_W-1:0]  src;
    logic [SRC_W-1:0]  right;
    logic              nat;
    logic              qp;
    logic [PRED_W-1:0] p1;
    logic [PRED_W-1:0] p2;
  } dec_t;

  function automatic logic [2:0] base_rel(input logic [1:0] op);
    logic [2:0] r;
    unique case (op)
      OP_AND_TYPES: r = REL_LT;
      OP_OR_TYPES:  r = REL_LTU;
      default:      r = REL_EQ;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] par_type(input logic [1:0] op);
    logic [2:0] t;
    unique case (op)
      OP_AND_TYPES: t = CT_AND;
      OP_OR_TYPES:  t = CT_OR;
      default:      t = CT_ORANDCM;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] ineq_rel(input logic [1:0] tac);
    logic [2:0] r;
    unique case (tac)
      TAC_NONE: r = REL_GT;
      TAC_UNC:  r = REL_LE;
      TAC_EQ:   r = REL_GE;
      default:  r = REL_LT;
    endcase
    return r;
  endfunction

endpackage

>>> src/pcu_if.sv
interface pcu_cmd_if
  import pcu_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               major_op;
  logic [1:0]               size_imm_select;
  logic [2:0]               completer_bits;
  logic                     qualify_true;
  logic [SRC_W-1:0]         left_value;
  logic                     left_nat;
  logic [SRC_W-1:0]         right_value;
  logic                     right_nat;
  logic signed [IMM_W-1:0]  imm_operand;
  logic [PRED_W-1:0]        first_pred;
  logic [PRED_W-1:0]        second_pred;

  modport source (
    output valid, major_op, size_imm_select, completer_bits, qualify_true,
           left_value, left_nat, right_value, right_nat, imm_operand,
           first_pred, second_pred,
    input  ready
  );
  modport sink (
    input  valid, major_op, size_imm_select, completer_bits, qualify_true,
           left_value, left_nat, right_value, right_nat, imm_operand,
           first_pred, second_pred,
    output ready
  );
endinterface

interface pcu_res_if
  import pcu_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              first_write;
  logic              first_bit;
  logic              second_write;
  logic              second_bit;
  logic [PRED_W-1:0] first_target;
  logic [PRED_W-1:0] second_target;
  logic              illegal_fault;
  logic              unimplemented;

  modport source (
    output valid, first_write, first_bit, second_write, second_bit,
           first_target, second_target, illegal_fault, unimplemented,
    input  ready
  );
  modport sink (
    input  valid, first_write, first_bit, second_write, second_bit,
           first_target, second_target, illegal_fault, unimplemented,
    output ready
  );
endinterface

>>> src/pcu_front.sv
module pcu_front
  import pcu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  pcu_cmd_if.sink cmd,
  output logic    dec_valid,
  output dec_t    dec,
  input  logic    dec_ready
);

  dec_t       dec_next;
  logic [1:0] tac;
  logic       immf;
  logic       tb;

  assign cmd.ready = !dec_valid || dec_ready;
  assign tac  = cmd.completer_bits[1:0];
  assign tb   = cmd.completer_bits[2];
  assign immf = cmd.size_imm_select[1];

  always_comb begin
    dec_next        = '0;
    dec_next.active = (cmd.major_op != OP_NOT_COMPARE) && !cmd.size_imm_select[0];
    dec_next.unimpl = (cmd.major_op != OP_NOT_COMPARE) && cmd.size_imm_select[0];
    dec_next.right  = cmd.right_value;
    dec_next.qp     = cmd.qualify_true;
    dec_next.p1     = cmd.first_pred;
    dec_next.p2     = cmd.second_pred;
    if (!immf && tb) begin
      dec_next.rel   = ineq_rel(tac);
      dec_next.ctype = par_type(cmd.major_op);
      dec_next.src   = '0;
      dec_next.nat   = cmd.right_nat;
    end else begin
      unique case (tac)
        TAC_NONE: begin
          dec_next.rel   = base_rel(cmd.major_op);
          dec_next.ctype = CT_NONE;
        end
        TAC_UNC: begin
          dec_next.rel   = base_rel(cmd.major_op);
          dec_next.ctype = CT_UNC;
        end
        TAC_EQ: begin
          dec_next.rel   = REL_EQ;
          dec_next.ctype = par_type(cmd.major_op);
        end
        default: begin
          dec_next.rel   = REL_NE;
          dec_next.ctype = par_type(cmd.major_op);
        end
      endcase
      if (immf) begin
        dec_next.src = SRC_W'(signed'(cmd.imm_operand));
        dec_next.nat = cmd.right_nat;
      end else begin
        dec_next.src = cmd.left_value;
        dec_next.nat = cmd.left_nat || cmd.right_nat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else if (cmd.ready) begin
      dec_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      dec <= dec_next;
    end
  end

endmodule

>>> src/pcu_queue.sv
module pcu_queue
  import pcu_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  dec_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output dec_t pop_data,
  input  logic pop_ready
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  dec_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = count != CntW'(Depth);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("queue count above depth");

  a_push_fill: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");

  a_pop_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count missed a pop");

endmodule

>>> src/pcu_back.sv
module pcu_back
  import pcu_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     pop_valid,
  input  dec_t     pop_data,
  output logic     pop_ready,
  pcu_res_if.source res
);

  logic eq;
  logic lt_s;
  logic lt_u;
  logic r;
  logic exec;
  logic fault;
  logic w1;
  logic b1;
  logic w2;
  logic b2;

  assign pop_ready = !res.valid || res.ready;

  assign eq   = pop_data.src == pop_data.right;
  assign lt_s = $signed(pop_data.src) < $signed(pop_data.right);
  assign lt_u = pop_data.src < pop_data.right;

  always_comb begin
    unique case (pop_data.rel)
      REL_EQ:  r = eq;
      REL_NE:  r = !eq;
      REL_LT:  r = lt_s;
      REL_LE:  r = lt_s || eq;
      REL_GT:  r = !lt_s && !eq;
      REL_GE:  r = !lt_s;
      default: r = lt_u;
    endcase
  end

  assign exec  = pop_data.active && (pop_data.qp || pop_data.ctype == CT_UNC);
  assign fault = exec && (pop_data.p1 == pop_data.p2);

  always_comb begin
    w1 = 1'b0;
    b1 = 1'b0;
    w2 = 1'b0;
    b2 = 1'b0;
    if (exec && !fault) begin
      if (!pop_data.qp) begin
        w1 = 1'b1;
        w2 = 1'b1;
      end else begin
        case (pop_data.ctype)
          CT_AND: begin
            w1 = pop_data.nat || !r;
            w2 = pop_data.nat || !r;
          end
          CT_OR: begin
            w1 = !pop_data.nat && r;
            w2 = !pop_data.nat && r;
            b1 = !pop_data.nat && r;
            b2 = !pop_data.nat && r;
          end
          CT_ORANDCM: begin
            w1 = !pop_data.nat && r;
            w2 = !pop_data.nat && r;
            b1 = !pop_data.nat && r;
          end
          default: begin
            w1 = 1'b1;
            w2 = 1'b1;
            b1 = !pop_data.nat && r;
            b2 = !pop_data.nat && !r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (pop_ready) begin
      res.valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      res.first_write   <= w1;
      res.first_bit     <= b1;
      res.second_write  <= w2;
      res.second_bit    <= b2;
      res.first_target  <= pop_data.p1;
      res.second_target <= pop_data.p2;
      res.illegal_fault <= fault;
      res.unimplemented <= pop_data.unimpl;
    end
  end

  a_unimpl_quiet: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.unimplemented |->
      !res.first_write && !res.second_write && !res.illegal_fault)
    else $error("unimplemented compare produced writes or a fault");

  a_fault_quiet: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.illegal_fault |->
      !res.first_write && !res.second_write &&
      res.first_target == res.second_target)
    else $error("illegal fault with writes or distinct targets");

  a_bit_needs_write: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.first_write || !res.first_bit) &&
                  (res.second_write || !res.second_bit))
    else $error("predicate bit set without its write enable");

endmodule

>>> src/predicate_compare_unit_core.sv
// integer compare to predicate targets
// cmd channel (sink): one decoded compare per transfer, major op, x2 field,
// tb/ta/c bits, qualifying predicate, two sources with NaT bits, imm8 and
// the two target predicate indices
// res channel (source): write enables and values for p1 and p2, the targets,
// illegal fault (p1 equals p2 on a compare that executes) and unimplemented
// (cmp4 forms)
// pipeline: decode register, a small queue, then compare and result register
// one compare per cycle sustained while res is ready
// a stall on res holds the result register, fills the queue and then drops
// cmd ready; no transfer is lost or repeated
// rst (synchronous) empties the decode register, queue and result register
module predicate_compare_unit_core
  import pcu_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  pcu_cmd_if.sink   cmd,
  pcu_res_if.source res
);

  logic dec_valid;
  logic dec_ready;
  dec_t dec;
  logic pop_valid;
  logic pop_ready;
  dec_t pop_data;

  pcu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .dec_valid (dec_valid),
    .dec       (dec),
    .dec_ready (dec_ready)
  );

  pcu_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (dec_valid),
    .push_data  (dec),
    .push_ready (dec_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  pcu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_data  (pop_data),
    .pop_ready (pop_ready),
    .res       (res)
  );

endmodule

>>> bench/tb_predicate_compare_unit_core.sv
module tb_predicate_compare_unit_core;
  import pcu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 600000;
  localparam int LongHold = 300;

  typedef struct packed {
    logic [1:0]        major_op;
    logic [1:0]        size_imm_select;
    logic [2:0]        completer_bits;
    logic              qualify_true;
    logic [SRC_W-1:0]  left_value;
    logic              left_nat;
    logic [SRC_W-1:0]  right_value;
    logic              right_nat;
    logic [IMM_W-1:0]  imm_operand;
    logic [PRED_W-1:0] first_pred;
    logic [PRED_W-1:0] second_pred;
  } cmp_cmd_t;

  typedef struct packed {
    logic              first_write;
    logic              first_bit;
    logic              second_write;
    logic              second_bit;
    logic [PRED_W-1:0] first_target;
    logic [PRED_W-1:0] second_target;
    logic              illegal_fault;
    logic              unimplemented;
  } pred_write_t;

  class compare_scoreboard;
    pred_write_t expected_writes[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_writes.size();
    endfunction

    function pred_write_t predict_writes(cmp_cmd_t c);
      pred_write_t r;
      logic [2:0] rel;
      logic [2:0] ctype;
      logic [2:0] par;
      logic [2:0] base;
      logic [SRC_W-1:0] src;
      logic nat;
      logic hit;
      logic immf;
      r = '0;
      r.first_target = c.first_pred;
      r.second_target = c.second_pred;
      if (c.major_op == OP_NOT_COMPARE) return r;
      if (c.size_imm_select[0]) begin
        r.unimplemented = 1'b1;
        return r;
      end
      case (c.major_op)
        OP_AND_TYPES: begin
          base = REL_LT;
          par = CT_AND;
        end
        OP_OR_TYPES: begin
          base = REL_LTU;
          par = CT_OR;
        end
        default: begin
          base = REL_EQ;
          par = CT_ORANDCM;
        end
      endcase
      immf = c.size_imm_select[1];
      if (!immf && c.completer_bits[2]) begin
        case (c.completer_bits[1:0])
          TAC_NONE: rel = REL_GT;
          TAC_UNC:  rel = REL_LE;
          TAC_EQ:   rel = REL_GE;
          default:  rel = REL_LT;
        endcase
        ctype = par;
        src = '0;
        nat = c.right_nat;
      end else begin
        case (c.completer_bits[1:0])
          TAC_NONE: begin
            rel = base;
            ctype = CT_NONE;
          end
          TAC_UNC: begin
            rel = base;
            ctype = CT_UNC;
          end
          TAC_EQ: begin
            rel = REL_EQ;
            ctype = par;
          end
          default: begin
            rel = REL_NE;
            ctype = par;
          end
        endcase
        if (immf) begin
          src = {{(SRC_W-IMM_W){c.imm_operand[IMM_W-1]}}, c.imm_operand};
          nat = c.right_nat;
        end else begin
          src = c.left_value;
          nat = c.left_nat | c.right_nat;
        end
      end
      case (rel)
        REL_EQ:  hit = (src == c.right_value);
        REL_NE:  hit = (src != c.right_value);
        REL_LT:  hit = ($signed(src) < $signed(c.right_value));
        REL_LE:  hit = ($signed(src) <= $signed(c.right_value));
        REL_GT:  hit = ($signed(src) > $signed(c.right_value));
        REL_GE:  hit = ($signed(src) >= $signed(c.right_value));
        default: hit = (src < c.right_value);
      endcase
      if (c.qualify_true) begin
        if (c.first_pred == c.second_pred) begin
          r.illegal_fault = 1'b1;
        end else begin
          case (ctype)
            CT_AND: begin
              if (nat || !hit) begin
                r.first_write = 1'b1;
                r.second_write = 1'b1;
              end
            end
            CT_OR: begin
              if (!nat && hit) begin
                r.first_write = 1'b1;
                r.second_write = 1'b1;
                r.first_bit = 1'b1;
                r.second_bit = 1'b1;
              end
            end
            CT_ORANDCM: begin
              if (!nat && hit) begin
                r.first_write = 1'b1;
                r.second_write = 1'b1;
                r.first_bit = 1'b1;
              end
            end
            default: begin
              r.first_write = 1'b1;
              r.second_write = 1'b1;
              if (!nat) begin
                r.first_bit = hit;
                r.second_bit = !hit;
              end
            end
          endcase
        end
      end else if (ctype == CT_UNC) begin
        if (c.first_pred == c.second_pred) begin
          r.illegal_fault = 1'b1;
        end else begin
          r.first_write = 1'b1;
          r.second_write = 1'b1;
        end
      end
      return r;
    endfunction

    function void note_compare(cmp_cmd_t c);
      expected_writes.push_back(predict_writes(c));
    endfunction

    function void check_field(string name, logic [PRED_W-1:0] want, logic [PRED_W-1:0] got);
      if (got !== want) begin
        errors++;
        $error("%s expected %0d actual %0d", name, want, got);
      end
    endfunction

    function void check_bit(string name, logic want, logic got);
      if (got !== want) begin
        errors++;
        $error("%s expected %0d actual %0d", name, want, got);
      end
    endfunction

    function void check_writes(pred_write_t got);
      pred_write_t want;
      if (expected_writes.size() == 0) begin
        errors++;
        $error("result transfer with no pending compare");
        return;
      end
      want = expected_writes.pop_front();
      check_bit("first_write", want.first_write, got.first_write);
      check_bit("first_bit", want.first_bit, got.first_bit);
      check_bit("second_write", want.second_write, got.second_write);
      check_bit("second_bit", want.second_bit, got.second_bit);
      check_field("first_target", want.first_target, got.first_target);
      check_field("second_target", want.second_target, got.second_target);
      check_bit("illegal_fault", want.illegal_fault, got.illegal_fault);
      check_bit("unimplemented", want.unimplemented, got.unimplemented);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit calm = 1'b0;
  bit hold_go = 1'b0;
  int cycle_count = 0;
  compare_scoreboard sb = new();

  pcu_cmd_if cmd_if ();
  pcu_res_if res_if ();

  predicate_compare_unit_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .res (res_if)
  );

  always #6 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SRC_W-1:0] pick_value();
    int s;
    s = $urandom_range(0, 16) - 8;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7fff_ffff_ffff_ffff;
      4: return 64'(s);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cmp_cmd_t make_cmd(logic [1:0] op, logic [1:0] x2, logic [2:0] cb,
                                        logic qp, logic [SRC_W-1:0] lv, logic ln,
                                        logic [SRC_W-1:0] rv, logic rn, logic [IMM_W-1:0] imm,
                                        logic [PRED_W-1:0] p1, logic [PRED_W-1:0] p2);
    cmp_cmd_t c;
    c.major_op = op;
    c.size_imm_select = x2;
    c.completer_bits = cb;
    c.qualify_true = qp;
    c.left_value = lv;
    c.left_nat = ln;
    c.right_value = rv;
    c.right_nat = rn;
    c.imm_operand = imm;
    c.first_pred = p1;
    c.second_pred = p2;
    return c;
  endfunction

  function automatic cmp_cmd_t rand_cmd();
    cmp_cmd_t c;
    c.major_op = ($urandom_range(0, 99) < 92) ? 2'($urandom_range(0, 2)) : OP_NOT_COMPARE;
    c.size_imm_select = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 80) c.size_imm_select[0] = 1'b0;
    c.completer_bits = 3'($urandom_range(0, 7));
    c.qualify_true = ($urandom_range(0, 99) < 80);
    c.left_value = pick_value();
    c.right_value = ($urandom_range(0, 4) == 0) ? c.left_value : pick_value();
    c.left_nat = ($urandom_range(0, 9) == 0);
    c.right_nat = ($urandom_range(0, 9) == 0);
    c.imm_operand = IMM_W'($urandom_range(0, 255));
    if (c.size_imm_select[1] && $urandom_range(0, 4) == 0)
      c.right_value = {{(SRC_W-IMM_W){c.imm_operand[IMM_W-1]}}, c.imm_operand};
    c.first_pred = PRED_W'($urandom_range(0, 63));
    c.second_pred = ($urandom_range(0, 19) == 0) ? c.first_pred : 6'($urandom_range(0, 63));
    return c;
  endfunction

  task automatic send_compare(cmp_cmd_t c);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 1) == 1) gap = pick_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.major_op <= c.major_op;
    cmd_if.size_imm_select <= c.size_imm_select;
    cmd_if.completer_bits <= c.completer_bits;
    cmd_if.qualify_true <= c.qualify_true;
    cmd_if.left_value <= c.left_value;
    cmd_if.left_nat <= c.left_nat;
    cmd_if.right_value <= c.right_value;
    cmd_if.right_nat <= c.right_nat;
    cmd_if.imm_operand <= c.imm_operand;
    cmd_if.first_pred <= c.first_pred;
    cmd_if.second_pred <= c.second_pred;
    forever begin
      @(posedge clk);
      if (cmd_if.ready) break;
    end
    sb.note_compare(c);
  endtask

  task automatic send_random(int count);
    repeat (count) send_compare(rand_cmd());
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // result side
  initial begin
    int stall_left;
    bit hold_seen;
    pred_write_t got;
    stall_left = 0;
    hold_seen = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        got.first_write = res_if.first_write;
        got.first_bit = res_if.first_bit;
        got.second_write = res_if.second_write;
        got.second_bit = res_if.second_bit;
        got.first_target = res_if.first_target;
        got.second_target = res_if.second_target;
        got.illegal_fault = res_if.illegal_fault;
        got.unimplemented = res_if.unimplemented;
        sb.check_writes(got);
      end
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap() - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_predicate_compare_unit_core: errors");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.major_op <= '0;
    cmd_if.size_imm_select <= '0;
    cmd_if.completer_bits <= '0;
    cmd_if.qualify_true <= 1'b0;
    cmd_if.left_value <= '0;
    cmd_if.left_nat <= 1'b0;
    cmd_if.right_value <= '0;
    cmd_if.right_nat <= 1'b0;
    cmd_if.imm_operand <= '0;
    cmd_if.first_pred <= '0;
    cmd_if.second_pred <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every completer form, relations against zero included
    for (int cb = 0; cb < 8; cb++)
      send_compare(make_cmd(2'(cb % 3), 2'b00, 3'(cb), 1'b1, 64'hffff_ffff_ffff_fffd, 1'b0,
                            64'd7, 1'b0, 8'h00, 6'd1, 6'd2));
    // immediate extremes, tb ignored in immediate form
    send_compare(make_cmd(OP_AND_TYPES, 2'b10, 3'b000, 1'b1, '0, 1'b0,
                          64'h8000_0000_0000_0000, 1'b0, 8'h80, 6'd3, 6'd4));
    send_compare(make_cmd(OP_OR_TYPES, 2'b10, 3'b001, 1'b1, '0, 1'b1, '1, 1'b0, 8'h7f,
                          6'd5, 6'd6));
    send_compare(make_cmd(OP_ORANDCM_TYPES, 2'b10, 3'b111, 1'b1, '1, 1'b0, '0, 1'b0, 8'h00,
                          6'd7, 6'd8));
    // cmp4 forms
    send_compare(make_cmd(OP_AND_TYPES, 2'b01, 3'b000, 1'b1, '0, 1'b0, '0, 1'b0, 8'h00,
                          6'd9, 6'd9));
    send_compare(make_cmd(OP_OR_TYPES, 2'b11, 3'b001, 1'b0, '0, 1'b0, '0, 1'b0, 8'h00,
                          6'd10, 6'd11));
    // not a compare
    send_compare(make_cmd(OP_NOT_COMPARE, 2'b00, 3'b001, 1'b1, '0, 1'b0, '0, 1'b0, 8'h00,
                          6'd12, 6'd12));
    // equal targets, executed and unc with false qualifier
    send_compare(make_cmd(OP_AND_TYPES, 2'b00, 3'b000, 1'b1, 64'd1, 1'b0, 64'd2, 1'b0, 8'h00,
                          6'd13, 6'd13));
    send_compare(make_cmd(OP_OR_TYPES, 2'b00, 3'b001, 1'b0, 64'd1, 1'b0, 64'd2, 1'b0, 8'h00,
                          6'd14, 6'd14));
    // false qualifier
    send_compare(make_cmd(OP_ORANDCM_TYPES, 2'b00, 3'b001, 1'b0, '0, 1'b0, '0, 1'b0, 8'h00,
                          6'd63, 6'd0));
    send_compare(make_cmd(OP_AND_TYPES, 2'b00, 3'b000, 1'b0, '0, 1'b0, '1, 1'b0, 8'h00,
                          6'd0, 6'd63));
    // nat handling
    send_compare(make_cmd(OP_AND_TYPES, 2'b00, 3'b000, 1'b1, '0, 1'b1, '1, 1'b0, 8'h00,
                          6'd15, 6'd16));
    send_compare(make_cmd(OP_OR_TYPES, 2'b00, 3'b010, 1'b1, '0, 1'b0, '0, 1'b1, 8'h00,
                          6'd17, 6'd18));
    send_compare(make_cmd(OP_AND_TYPES, 2'b00, 3'b100, 1'b1, '0, 1'b1, 64'hffff_ffff_ffff_ff00,
                          1'b0, 8'h00, 6'd19, 6'd20));
    send_compare(make_cmd(OP_AND_TYPES, 2'b00, 3'b010, 1'b1, 64'd5, 1'b0, 64'd5, 1'b1, 8'h00,
                          6'd21, 6'd22));
    // signed versus unsigned extremes
    send_compare(make_cmd(OP_AND_TYPES, 2'b00, 3'b000, 1'b1, '1, 1'b0, '0, 1'b0, 8'h00,
                          6'd23, 6'd24));
    send_compare(make_cmd(OP_OR_TYPES, 2'b00, 3'b000, 1'b1, '1, 1'b0, '0, 1'b0, 8'h00,
                          6'd25, 6'd26));
    send_compare(make_cmd(OP_ORANDCM_TYPES, 2'b00, 3'b000, 1'b1, '1, 1'b0, '1, 1'b0, 8'h00,
                          6'd27, 6'd28));
    wait_drained();

    send_random(400);

    // long result stall while commands keep coming
    hold_go = ~hold_go;
    send_random(60);
    wait_drained();

    calm = 1'b1;
    send_random(300);
    calm = 1'b0;
    send_random(390);
    wait_drained();

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_predicate_compare_unit_core: clean");
    end else begin
      $display("tb_predicate_compare_unit_core: errors");
    end
    $finish;
  end

endmodule
